// ----- rtl/gbfr_pkg.sv -----
// Package for the binary GPS frame receiver: result item type, status codes,
// protocol constants and queue sizing. Depends on nothing.
`timescale 1ns / 1ps

package gbfr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hA0;
    localparam logic [7:0] SYNC_SECOND = 8'hA2;
    localparam logic [7:0] TAIL_FIRST  = 8'hB0;
    localparam logic [7:0] TAIL_SECOND = 8'hB3;

    localparam logic [15:0] MAX_LEN_RESET = 16'd1023;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] ST_GOOD        = 2'd0;
    localparam logic [1:0] ST_BAD_TRAILER = 2'd1;
    localparam logic [1:0] ST_TOO_LONG    = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       is_msg_id;
        logic [1:0] status;
    } t_result;

    // Write request from the parser into the result queue.
    typedef struct packed {
        logic    valid;
        t_result item;
    } t_q_write;

    // Queue status toward the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- rtl/gbfr_parser.sv -----
// Front part: frame state machine that classifies each received byte and
// issues at most one result request per byte. Depends on gbfr_pkg.
`timescale 1ns / 1ps

module gbfr_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_rx_byte,
    input  logic [15:0]        i_max_len,
    output gbfr_pkg::t_q_write o_wr
);
    import gbfr_pkg::*;

    typedef enum logic [8:0] {
        PH_HUNT1  = 9'b000000001,
        PH_HUNT2  = 9'b000000010,
        PH_LEN_HI = 9'b000000100,
        PH_LEN_LO = 9'b000001000,
        PH_BODY   = 9'b000010000,
        PH_CK_HI  = 9'b000100000,
        PH_CK_LO  = 9'b001000000,
        PH_TAIL1  = 9'b010000000,
        PH_TAIL2  = 9'b100000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_len, n_len;
    logic [15:0] r_seen, n_seen;
    logic        r_tail_bad, n_tail_bad;

    logic [15:0] len_full;
    logic [15:0] seen_inc;

    assign len_full = {r_len_hi, i_rx_byte};
    assign seen_inc = r_seen + 16'd1;

    always_comb begin
        n_phase    = r_phase;
        n_len_hi   = r_len_hi;
        n_len      = r_len;
        n_seen     = r_seen;
        n_tail_bad = r_tail_bad;
        o_wr       = '0;
        case (r_phase)
            PH_HUNT2: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_phase = PH_LEN_HI;
                end else if (i_rx_byte == SYNC_FIRST) begin
                    n_phase = PH_HUNT2;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_LEN_HI: begin
                n_len_hi = i_rx_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len      = len_full;
                n_seen     = '0;
                n_tail_bad = 1'b0;
                if (len_full > i_max_len) begin
                    n_phase            = PH_HUNT1;
                    o_wr.valid         = 1'b1;
                    o_wr.item.kind     = KIND_STATUS;
                    o_wr.item.status   = ST_TOO_LONG;
                end else if (len_full == 16'd0) begin
                    n_phase = PH_CK_HI;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_seen              = seen_inc;
                o_wr.valid          = 1'b1;
                o_wr.item.kind      = KIND_PAYLOAD;
                o_wr.item.data      = i_rx_byte;
                o_wr.item.is_msg_id = (r_seen == 16'd0);
                if (seen_inc >= r_len) begin
                    n_phase = PH_CK_HI;
                end
            end
            PH_CK_HI: begin
                n_phase = PH_CK_LO;
            end
            PH_CK_LO: begin
                n_phase = PH_TAIL1;
            end
            PH_TAIL1: begin
                n_tail_bad = (i_rx_byte != TAIL_FIRST);
                n_phase    = PH_TAIL2;
            end
            PH_TAIL2: begin
                n_tail_bad       = r_tail_bad || (i_rx_byte != TAIL_SECOND);
                n_phase          = PH_HUNT1;
                o_wr.valid       = 1'b1;
                o_wr.item.kind   = KIND_STATUS;
                o_wr.item.status = n_tail_bad ? ST_BAD_TRAILER : ST_GOOD;
            end
            default: begin
                n_phase = (i_rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
        o_wr.valid = o_wr.valid && i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT1;
            r_len      <= '0;
            r_seen     <= '0;
            r_tail_bad <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_len      <= n_len;
            r_seen     <= n_seen;
            r_tail_bad <= n_tail_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_len_hi <= n_len_hi;
        end
    end

endmodule

// ----- rtl/gbfr_queue.sv -----
// Back part: short result queue that holds finished result items until the
// consumer takes them. Depends on gbfr_pkg.
`timescale 1ns / 1ps

module gbfr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbfr_pkg::t_q_write  i_wr,
    input  logic                i_rd,
    output gbfr_pkg::t_result   o_head,
    output gbfr_pkg::t_q_status o_status
);
    import gbfr_pkg::*;

    t_result         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            do_rd;

    assign o_status.full  = (r_count == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_rd          = i_rd && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wr_ptr] <= i_wr.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            case ({i_wr.valid, do_rd})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/gps_binary_frame_receiver.sv -----
// Top level of the binary GPS frame receiver: configuration register, frame
// parser and result queue. Depends on gbfr_pkg, gbfr_parser and gbfr_queue.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         push / full          i_rx_byte
// result    out        empty / pop          o_out_kind, o_out_byte, o_is_msg_id,
//                                           o_frame_status
// config    in         i_cfg_we (no wait)   i_cfg_data (max_payload_len)
//
// One received byte is accepted per cycle whenever full is low; the parser
// handles it in the cycle it is accepted, so the sustained rate is one byte
// per clock while full stays low, set by the frame state machine.
// A result request appears on the result ports in the next cycle if the queue
// was empty, else behind earlier results. The four-entry result queue lets
// input flow while the consumer stalls; full rises only when four are waiting.
// Reset is synchronous and active low: it returns the parser to the hunt for
// the first sync byte, empties the queue and loads max_payload_len with 1023.

module gps_binary_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_is_msg_id,
    output logic [1:0]  o_frame_status,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import gbfr_pkg::*;

    logic [15:0] r_max_len;
    logic        in_accept;
    t_q_write    wr_req;
    t_result     head;
    t_q_status   q_status;

    // The limit register is written directly; software only changes it while no
    // frame is in flight, a rule the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    assign full      = q_status.full;
    assign empty     = q_status.empty;
    assign in_accept = push && !q_status.full;

    // Front part: every accepted byte advances the frame state machine; payload
    // bytes, frame-end status and too-long status become result requests.
    gbfr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .i_max_len (r_max_len),
        .o_wr      (wr_req)
    );

    // Back part: results wait here in order until the consumer pops them.
    gbfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr_req),
        .i_rd     (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    assign o_out_kind     = head.kind;
    assign o_out_byte     = head.data;
    assign o_is_msg_id    = head.is_msg_id;
    assign o_frame_status = head.status;

    // A queue of several entries can never be full and empty at once.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(full && empty))
        else $error("result queue is full and empty at once");

    // A frame-end status carries no byte and no message id flag.
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind == KIND_STATUS) |-> (o_out_byte == 8'd0 && !o_is_msg_id))
        else $error("status result carries payload fields");

    // A payload byte always reports a zero frame status.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind == KIND_PAYLOAD) |-> (o_frame_status == ST_GOOD))
        else $error("payload result carries a frame status");

    // Popping with no new byte frees a queue entry.
    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !push) |=> !full)
        else $error("queue still full after a pop with no push");

endmodule
